### sv/mat_pkg.sv
// Shared constants, register codes and types of the angle tracker.
package mat_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int TURN_BITS  = 16;
  localparam int OFF_BITS   = ANGLE_BITS + 1;
  localparam int PP_BITS    = 6;
  localparam int WIDE_BITS  = 16;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ANGLE_OFFSET = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLE_PAIRS   = 1'b1;

  localparam logic [OFF_BITS-1:0] OFFSET_RESET = OFF_BITS'(-53);
  localparam logic [PP_BITS-1:0]  POLE_RESET   = PP_BITS'(21);

  typedef logic [ANGLE_BITS-1:0] angle_t;

  typedef struct packed {
    logic signed [ANGLE_BITS:0]  speed;
    logic                        reverse;
    logic signed [TURN_BITS-1:0] turns;
    logic [ANGLE_BITS:0]         reducer;
  } track_t;

endpackage

### sv/magnetic_encoder_angle_tracker.sv
// Top level: config registers, input and result registers of the tracker.
// Path: an accepted request is held in the input register, then moves to the result register.
// Throughput: one request per cycle while results are taken; the result register and input register
// form a two-stage pipeline with backpressure.
// Reset: synchronous active-low; clears valids and tracking state, loads
// offset -53 and 21 pole pairs.
module magnetic_encoder_angle_tracker
  import mat_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [OFF_BITS-1:0]          cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ANGLE_BITS-1:0]        in_raw_angle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ANGLE_BITS-1:0]        out_calibrated_angle,
  output logic [ANGLE_BITS-1:0]        out_electrical_angle,
  output logic [WIDE_BITS-1:0]         out_electrical_angle_wide,
  output logic signed [ANGLE_BITS:0]   out_speed_counts,
  output logic                         out_reverse_dir,
  output logic signed [TURN_BITS-1:0]  out_turn_count,
  output logic [ANGLE_BITS:0]          out_reducer_position
);

  logic [OFF_BITS-1:0] offset_r;
  logic [PP_BITS-1:0]  pole_r;
  logic                in_vld_r;
  angle_t              raw_r;
  logic                out_vld_r;
  logic                advance;

  angle_t               cal, elec;
  logic [WIDE_BITS-1:0] wide;
  track_t               trk;

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
      pole_r   <= POLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANGLE_OFFSET: offset_r <= cfg_wdata;
        CFG_POLE_PAIRS:   pole_r   <= cfg_wdata[PP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (advance) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) raw_r <= in_raw_angle;
  end

  mat_angle u_angle (
    .raw        (raw_r),
    .offset     (offset_r),
    .pole_pairs (pole_r),
    .cal        (cal),
    .elec       (elec),
    .wide       (wide)
  );

  mat_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cal     (cal),
    .trk     (trk)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      out_calibrated_angle      <= cal;
      out_electrical_angle      <= elec;
      out_electrical_angle_wide <= wide;
      out_speed_counts          <= trk.speed;
      out_reverse_dir           <= trk.reverse;
      out_turn_count            <= trk.turns;
      out_reducer_position      <= trk.reducer;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with empty result register");

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_speed_counts <= $signed({2'b01, {(ANGLE_BITS-1){1'b0}}})
                && out_speed_counts >= -$signed({2'b01, {(ANGLE_BITS-1){1'b0}}})))
    else $error("speed outside half a turn");

  a_dir_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_speed_counts > 0) |-> !out_reverse_dir)
    else $error("positive speed flagged reverse");

  a_rev_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_reverse_dir) |-> (out_reducer_position != '0))
    else $error("reverse reducer position zero");

endmodule

### sv/mat_angle.sv
// Calibrated, electrical and wide electrical angle of one raw sample.
module mat_angle
  import mat_pkg::*;
(
  input  angle_t                raw,
  input  logic [OFF_BITS-1:0]   offset,
  input  logic [PP_BITS-1:0]    pole_pairs,
  output angle_t                cal,
  output angle_t                elec,
  output logic [WIDE_BITS-1:0]  wide
);

  logic [ANGLE_BITS+PP_BITS-1:0] prod;

  // only the low angle bits of the offset matter modulo one turn
  assign cal  = angle_t'(angle_t'(0) - raw - offset[ANGLE_BITS-1:0]);
  assign prod = {{PP_BITS{1'b0}}, cal} * {{ANGLE_BITS{1'b0}}, pole_pairs};
  assign elec = prod[ANGLE_BITS-1:0];
  assign wide = WIDE_BITS'(elec) << (WIDE_BITS - ANGLE_BITS);

endmodule

### sv/mat_track.sv
// Turn counter, direction and speed state, and reducer position.
module mat_track
  import mat_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   advance,
  input  angle_t cal,
  output track_t trk
);

  localparam logic [ANGLE_BITS:0] FULL_U = {1'b1, {ANGLE_BITS{1'b0}}};
  localparam logic signed [ANGLE_BITS:0] HALF_S = {2'b01, {(ANGLE_BITS-1){1'b0}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  angle_t                      prev_r;
  logic signed [TURN_BITS-1:0] turns_r, turns_nxt;
  logic                        dir_r, dir_nxt;

  logic signed [ANGLE_BITS:0]  diff, speed;
  logic [TURN_BITS-1:0]        mag;
  angle_t                      qterm, fwd, rsum;
  logic [ANGLE_BITS:0]         tmc;

  always_comb begin
    diff = $signed({1'b0, cal}) - $signed({1'b0, prev_r});
    // adding or subtracting one turn is the same modulo 2^(ANGLE_BITS+1)
    if (diff > HALF_S || diff < -HALF_S) begin
      speed = diff + $signed(FULL_U);
    end else begin
      speed = diff;
    end

    turns_nxt = turns_r;
    if (diff > HALF_S) begin
      if (turns_r != TURN_MIN) turns_nxt = turns_r - TURN_BITS'(1);
    end else if (diff < -HALF_S) begin
      if (turns_r != TURN_MAX) turns_nxt = turns_r + TURN_BITS'(1);
    end

    dir_nxt = dir_r;
    if (speed > 0) dir_nxt = 1'b0;
    else if (speed < 0) dir_nxt = 1'b1;

    mag   = turns_nxt[TURN_BITS-1] ? TURN_BITS'(-turns_nxt) : turns_nxt;
    qterm = {mag[1:0], {(ANGLE_BITS-2){1'b0}}};
    fwd   = angle_t'(qterm + (cal >> 2));
    tmc   = FULL_U - {1'b0, cal};
    rsum  = angle_t'(qterm + angle_t'(tmc >> 2));

    trk.speed   = speed;
    trk.reverse = dir_nxt;
    trk.turns   = turns_nxt;
    trk.reducer = dir_nxt ? (FULL_U - {1'b0, rsum}) : {1'b0, fwd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      turns_r <= '0;
      dir_r   <= 1'b0;
    end else if (advance) begin
      prev_r  <= cal;
      turns_r <= turns_nxt;
      dir_r   <= dir_nxt;
    end
  end

endmodule

### sim/tb_magnetic_encoder_angle_tracker.sv
// Self-checking testbench of the encoder angle tracker: directed, random and turn-wrap runs.
`timescale 1ns / 1ps

module tb_magnetic_encoder_angle_tracker;
  import mat_pkg::*;

  localparam int FULL_TURN   = 1 << ANGLE_BITS;
  localparam int HALF_TURN   = FULL_TURN / 2;
  localparam int QUARTER     = FULL_TURN / 4;
  localparam int TURN_MAX    = (1 << (TURN_BITS - 1)) - 1;
  localparam int TURN_MIN    = -TURN_MAX - 1;
  localparam int CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic [ANGLE_BITS-1:0]       cal;
    logic [ANGLE_BITS-1:0]       elec;
    logic [WIDE_BITS-1:0]        wide;
    logic signed [ANGLE_BITS:0]  speed;
    logic                        reverse;
    logic signed [TURN_BITS-1:0] turns;
    logic [ANGLE_BITS:0]         reducer;
  } angle_result_t;

  typedef struct {
    angle_t raw;
    int     gap;
  } sample_req_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]     cfg_index = '0;
  logic [OFF_BITS-1:0]         cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [ANGLE_BITS-1:0]       in_raw_angle = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [ANGLE_BITS-1:0]       out_calibrated_angle;
  logic [ANGLE_BITS-1:0]       out_electrical_angle;
  logic [WIDE_BITS-1:0]        out_electrical_angle_wide;
  logic signed [ANGLE_BITS:0]  out_speed_counts;
  logic                        out_reverse_dir;
  logic signed [TURN_BITS-1:0] out_turn_count;
  logic [ANGLE_BITS:0]         out_reducer_position;

  magnetic_encoder_angle_tracker DUT (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_wdata                 (cfg_wdata),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_raw_angle              (in_raw_angle),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_calibrated_angle      (out_calibrated_angle),
    .out_electrical_angle      (out_electrical_angle),
    .out_electrical_angle_wide (out_electrical_angle_wide),
    .out_speed_counts          (out_speed_counts),
    .out_reverse_dir           (out_reverse_dir),
    .out_turn_count            (out_turn_count),
    .out_reducer_position      (out_reducer_position)
  );

  // mirror of the tracker registers and state
  logic [OFF_BITS-1:0] offset_reg = OFFSET_RESET;
  logic [PP_BITS-1:0]  pole_reg = POLE_RESET;
  angle_t              last_angle = '0;
  int                  turn_total = 0;
  logic                reverse_state = 1'b0;

  sample_req_t   pending_samples[$];
  angle_result_t expected_tracks[$];
  sample_req_t   next_sample;
  angle_result_t got_track;
  angle_result_t want_track;

  bit burst_mode = 1'b0;
  int idle_wait = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int sample_count = 0;
  int result_count = 0;
  int mismatch_count = 0;
  int setting_count = 1;
  int turn_low = 0;
  int turn_high = 0;
  int heading;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_tracks.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int draw_idle();
    if (burst_mode || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic angle_result_t track_sample(angle_t raw);
    angle_result_t r;
    angle_t        cal;
    int            diff;
    int            spd;
    int            mag;
    int            red;
    cal  = 12'd0 - raw - offset_reg[ANGLE_BITS-1:0];
    diff = int'(cal) - int'(last_angle);
    spd  = diff;
    if (spd > HALF_TURN) spd -= FULL_TURN;
    else if (spd < -HALF_TURN) spd += FULL_TURN;
    if (diff > HALF_TURN) begin
      if (turn_total > TURN_MIN) turn_total--;
    end else if (diff < -HALF_TURN) begin
      if (turn_total < TURN_MAX) turn_total++;
    end
    if (spd > 0) reverse_state = 1'b0;
    else if (spd < 0) reverse_state = 1'b1;
    last_angle = cal;
    mag = (turn_total < 0) ? -turn_total : turn_total;
    if (!reverse_state) begin
      red = (mag * QUARTER + int'(cal) / 4) & (FULL_TURN - 1);
    end else begin
      red = FULL_TURN - ((mag * QUARTER + (FULL_TURN - int'(cal)) / 4) & (FULL_TURN - 1));
    end
    if (turn_total < turn_low) turn_low = turn_total;
    if (turn_total > turn_high) turn_high = turn_total;
    r.cal     = cal;
    r.elec    = angle_t'(cal * pole_reg);
    r.wide    = {r.elec, {(WIDE_BITS - ANGLE_BITS){1'b0}}};
    r.speed   = (ANGLE_BITS + 1)'(spd);
    r.reverse = reverse_state;
    r.turns   = TURN_BITS'(turn_total);
    r.reducer = (ANGLE_BITS + 1)'(red);
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_tracks.push_back(track_sample(in_raw_angle));
        sample_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && idle_wait >= pending_samples[0].gap) begin
          next_sample = pending_samples.pop_front();
          in_raw_angle <= next_sample.raw;
          in_valid <= 1'b1;
          idle_wait = 0;
        end else begin
          in_valid <= 1'b0;
          if (pending_samples.size() != 0) idle_wait++;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got_track.cal     = out_calibrated_angle;
        got_track.elec    = out_electrical_angle;
        got_track.wide    = out_electrical_angle_wide;
        got_track.speed   = out_speed_counts;
        got_track.reverse = out_reverse_dir;
        got_track.turns   = out_turn_count;
        got_track.reducer = out_reducer_position;
        result_count++;
        if (expected_tracks.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d arrived with no request outstanding", result_count);
        end else begin
          want_track = expected_tracks.pop_front();
          if (got_track.cal !== want_track.cal || got_track.elec !== want_track.elec ||
              got_track.wide !== want_track.wide || got_track.speed !== want_track.speed ||
              got_track.reverse !== want_track.reverse ||
              got_track.turns !== want_track.turns ||
              got_track.reducer !== want_track.reducer) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result %0d exp cal=%0d elec=%0d wide=%0d spd=%0d rev=%0b turns=%0d red=%0d",
                       result_count, want_track.cal, want_track.elec, want_track.wide,
                       want_track.speed, want_track.reverse, want_track.turns,
                       want_track.reducer);
              $display("result %0d got cal=%0d elec=%0d wide=%0d spd=%0d rev=%0b turns=%0d red=%0d",
                       result_count, got_track.cal, got_track.elec, got_track.wide,
                       got_track.speed, got_track.reverse, got_track.turns,
                       got_track.reducer);
            end
          end
        end
        stall_left = draw_idle();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_sample(angle_t raw);
    sample_req_t s;
    s.raw = raw;
    s.gap = draw_idle();
    pending_samples.push_back(s);
  endtask

  // queue the raw angle that calibrates to the given angle
  task automatic push_cal(angle_t cal);
    push_sample(12'd0 - cal - offset_reg[ANGLE_BITS-1:0]);
  endtask

  task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [OFF_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ANGLE_OFFSET) offset_reg = data;
    else pole_reg = data[PP_BITS-1:0];
  endtask

  task automatic set_tracker_config(logic [OFF_BITS-1:0] offset, logic [OFF_BITS-1:0] poles);
    write_register(CFG_ANGLE_OFFSET, offset);
    write_register(CFG_POLE_PAIRS, poles);
    setting_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_tracks.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // rotation runs with random speed, mixed with jumps, holds and half-turn steps
  task automatic queue_random_samples(int count);
    int produced;
    int run;
    int vel;
    produced = 0;
    heading  = int'(last_angle);
    while (produced < count) begin
      if ($urandom_range(0, 9) < 6) begin
        run = $urandom_range(4, 40);
        case ($urandom_range(0, 3))
          0: vel = int'($urandom_range(0, 40)) - 20;
          1: vel = int'($urandom_range(0, 4094)) - 2047;
          2: vel = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(2040, 2048));
          default: vel = int'($urandom_range(0, 400)) - 200;
        endcase
        repeat (run) begin
          heading = (heading + vel) & (FULL_TURN - 1);
          push_cal(angle_t'(heading));
          produced++;
        end
      end else begin
        case ($urandom_range(0, 2))
          0: heading = $urandom_range(0, FULL_TURN - 1);
          1: ;
          default: heading = (heading + HALF_TURN) & (FULL_TURN - 1);
        endcase
        push_cal(angle_t'(heading));
        produced++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: first sample against zero, half-turn steps, hold, both wraps
    push_sample(12'h000);
    push_sample(12'hFFF);
    push_cal(12'd0);
    push_cal(12'd2048);
    push_cal(12'd0);
    push_cal(12'd0);
    push_cal(12'd4000);
    push_cal(12'd50);
    push_cal(12'd4000);
    push_cal(12'd2000);
    wait_drained();

    set_tracker_config(13'd4095, 13'd63);
    push_sample(12'h000);
    push_sample(12'hFFF);
    push_sample(12'h800);
    wait_drained();

    // zero pole pairs
    set_tracker_config(OFF_BITS'(-4095), 13'd0);
    push_sample(12'h000);
    push_sample(12'hFFF);
    push_sample(12'h4D2);
    wait_drained();

    set_tracker_config(13'h1000, 13'h1FC1);
    push_sample(12'h000);
    push_sample(12'hFFF);
    wait_drained();

    set_tracker_config(13'd0, 13'd1);
    push_sample(12'h000);
    push_sample(12'hFFF);
    push_sample(12'h555);
    push_sample(12'hAAA);
    wait_drained();

    for (int k = 0; k < 6; k++) begin
      case (k)
        1: set_tracker_config(13'd4095, 13'd1);
        2: set_tracker_config(OFF_BITS'(-4095), 13'd63);
        3: set_tracker_config(13'd0, 13'd0);
        default: set_tracker_config(OFF_BITS'($urandom), OFF_BITS'($urandom));
      endcase
      burst_mode = (k == 4);
      queue_random_samples(230);
      wait_drained();
    end

    // repeated wraps up, then down past zero to negative turn counts, then up again
    set_tracker_config(OFF_BITS'($urandom), OFF_BITS'($urandom));
    burst_mode = 1'b1;
    repeat (50) begin
      push_cal(12'd0);
      push_cal(12'd1365);
      push_cal(12'd2730);
    end
    wait_drained();
    repeat (100) begin
      push_cal(12'd2730);
      push_cal(12'd1365);
      push_cal(12'd0);
    end
    repeat (3) begin
      push_cal(12'd1365);
      push_cal(12'd2730);
      push_cal(12'd0);
    end
    wait_drained();
    burst_mode = 1'b0;

    set_tracker_config(OFFSET_RESET, OFF_BITS'(POLE_RESET));
    queue_random_samples(60);
    wait_drained();
    repeat (8) @(negedge clk);

    if (expected_tracks.size() != 0) mismatch_count++;
    $display("Covered %0d samples under %0d register settings, with wraps both ways",
             sample_count, setting_count);
    $display("Turn count spanned %0d to %0d; %0d mismatches", turn_low, turn_high,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
